// File: design/lfac_pkg.sv
// Shared constants, command codes and result type for the LRU cache.
`timescale 1ns / 1ps

package lfac_pkg;

  localparam int CAPACITY  = 16;
  localparam int KEY_BITS  = 32;
  localparam int DATA_BITS = 32;

  localparam int OPCODE_W  = 2;
  localparam int KEY_IN_W  = 32;
  localparam int DATA_IN_W = 32;
  localparam int OUT_W     = 32;

  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOOKUP,
    CMD_INSERT,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    logic             hit;
    logic [OUT_W-1:0] found_value;
  } result_t;

endpackage

// File: design/lfac_fifo.sv
// Small synchronous queue with valid/ready on both sides.
`timescale 1ns / 1ps

module lfac_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != CW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = slot_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_ready_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: design/lfac_front.sv
// Input stage: accepts beats, decodes the opcode and trims key and data words.
`timescale 1ns / 1ps

module lfac_front #(
  parameter int KEY_BITS  = lfac_pkg::KEY_BITS,
  parameter int DATA_BITS = lfac_pkg::DATA_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic [lfac_pkg::OPCODE_W-1:0]      opcode_i,
  input  logic [lfac_pkg::KEY_IN_W-1:0]      search_key_i,
  input  logic [lfac_pkg::DATA_IN_W-1:0]     new_value_i,
  output logic                               cmd_valid_o,
  input  logic                               cmd_ready_i,
  output lfac_pkg::cmd_kind_e                cmd_kind_o,
  output logic [KEY_BITS-1:0]                cmd_key_o,
  output logic [DATA_BITS-1:0]               cmd_value_o
);

  logic                 valid_q;
  lfac_pkg::cmd_kind_e  kind_q, kind_d;
  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] value_q;
  logic                 take;

  assign full_o      = valid_q && !cmd_ready_i;
  assign take        = push_i && !full_o;
  assign cmd_valid_o = valid_q;
  assign cmd_kind_o  = kind_q;
  assign cmd_key_o   = key_q;
  assign cmd_value_o = value_q;

  always_comb begin
    case (opcode_i)
      lfac_pkg::OP_LOOKUP: kind_d = lfac_pkg::CMD_LOOKUP;
      lfac_pkg::OP_INSERT: kind_d = lfac_pkg::CMD_INSERT;
      lfac_pkg::OP_CLEAR:  kind_d = lfac_pkg::CMD_CLEAR;
      default:             kind_d = lfac_pkg::CMD_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      kind_q  <= lfac_pkg::CMD_NOP;
    end else begin
      if (take) begin
        valid_q <= 1'b1;
        kind_q  <= kind_d;
      end else if (cmd_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      key_q   <= KEY_BITS'(search_key_i);
      value_q <= DATA_BITS'(new_value_i);
    end
  end

endmodule

// File: design/lfac_back.sv
// Cache engine: tag compare, recency select and update, data store.
`timescale 1ns / 1ps

module lfac_back #(
  parameter int CAPACITY  = lfac_pkg::CAPACITY,
  parameter int KEY_BITS  = lfac_pkg::KEY_BITS,
  parameter int DATA_BITS = lfac_pkg::DATA_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_pop_o,
  input  lfac_pkg::cmd_kind_e  cmd_kind_i,
  input  logic [KEY_BITS-1:0]  cmd_key_i,
  input  logic [DATA_BITS-1:0] cmd_value_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output lfac_pkg::result_t    res_o
);

  localparam int RW = $clog2(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_PRO  = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [2:0]           state_q, state_d;
  lfac_pkg::cmd_kind_e  kind_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] value_q;
  logic                 hit_q;
  logic [RW-1:0]        sel_rank_q;
  logic [CAPACITY-1:0]  match_q, match_d;
  logic [CAPACITY-1:0]  valid_q;
  logic [RW-1:0]        rank_q [CAPACITY];
  logic [KEY_BITS-1:0]  tag_q  [CAPACITY];
  logic [DATA_BITS-1:0] data_mem [CAPACITY];
  logic [DATA_BITS-1:0] rd_q;

  logic [CAPACITY-1:0]  by_rank;
  logic                 low_found;
  logic [RW-1:0]        low_rank;
  logic [RW-1:0]        sel_idx;
  logic [63:0]          rd_wide;
  logic                 do_write;

  always_comb begin
    match_d  = '0;
    by_rank  = '0;
    low_rank = '0;
    sel_idx  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_d[i] = valid_q[i] && (tag_q[i] == key_q);
      by_rank[rank_q[i]] = by_rank[rank_q[i]] | match_q[i];
      if (rank_q[i] == sel_rank_q) begin
        sel_idx = sel_idx | RW'(i);
      end
    end
    for (int r = CAPACITY - 1; r >= 0; r--) begin
      if (by_rank[r]) begin
        low_rank = RW'(r);
      end
    end
    low_found = |by_rank;
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) state_d = S_CMP;
      end
      S_CMP: begin
        case (kind_q)
          lfac_pkg::CMD_LOOKUP: state_d = S_SEL;
          lfac_pkg::CMD_INSERT: state_d = S_PRO;
          default:              state_d = S_RES;
        endcase
      end
      S_SEL: state_d = low_found ? S_PRO : S_RES;
      S_PRO: state_d = S_RES;
      S_RES: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign do_write = (state_q == S_PRO) && (kind_q == lfac_pkg::CMD_INSERT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= lfac_pkg::CMD_NOP;
      hit_q   <= 1'b0;
      valid_q <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_q[i] <= RW'(i);
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && cmd_valid_i) begin
        kind_q <= cmd_kind_i;
        hit_q  <= 1'b0;
      end
      if (state_q == S_CMP && kind_q == lfac_pkg::CMD_CLEAR) begin
        valid_q <= '0;
      end
      if (state_q == S_SEL && low_found) begin
        hit_q <= 1'b1;
      end
      if (state_q == S_PRO) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (rank_q[i] < sel_rank_q) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end else if (rank_q[i] == sel_rank_q) begin
            rank_q[i] <= '0;
          end
        end
      end
      if (do_write) begin
        valid_q[sel_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && cmd_valid_i) begin
      key_q   <= cmd_key_i;
      value_q <= cmd_value_i;
    end
    if (state_q == S_CMP) begin
      match_q <= match_d;
      if (kind_q == lfac_pkg::CMD_INSERT) begin
        sel_rank_q <= RW'(CAPACITY - 1);
      end
    end
    if (state_q == S_SEL) begin
      sel_rank_q <= low_rank;
    end
    if (do_write) begin
      tag_q[sel_idx] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      data_mem[sel_idx] <= value_q;
    end
    if (state_q == S_PRO) begin
      rd_q <= data_mem[sel_idx];
    end
  end

  assign rd_wide           = 64'(rd_q);
  assign res_valid_o       = (state_q == S_RES);
  assign res_o.hit         = hit_q;
  assign res_o.found_value = hit_q ? rd_wide[lfac_pkg::OUT_W-1:0] : '0;

endmodule

// File: design/lru_fully_associative_cache.sv
// Top level of the fully associative LRU cache.
`timescale 1ns / 1ps

// Fully associative cache of CAPACITY entries held in strict recency order.
// Every beat on the input queue (lookup, insert, clear, or an unused opcode
// that changes nothing) yields exactly one result beat, in order. A lookup
// returns the data of the most recent valid entry with a matching key and
// makes it most recent; an insert replaces the least recent entry without a
// duplicate check; clear drops all entries and keeps the recency order.
// Beats pass a one-entry input stage and a two-entry command queue into a
// single compare and rank-update engine, which steps through compare,
// lowest-rank select for a lookup, rank update with data read for a lookup
// hit or an insert, and result; a clear or unused opcode goes from compare
// straight to result. Results wait in a two-entry result queue.
// Tag compare and rank update act on all entries in parallel.

module lru_fully_associative_cache #(
  parameter int CAPACITY  = lfac_pkg::CAPACITY,
  parameter int KEY_BITS  = lfac_pkg::KEY_BITS,
  parameter int DATA_BITS = lfac_pkg::DATA_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [lfac_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [lfac_pkg::KEY_IN_W-1:0]  search_key_i,
  input  logic [lfac_pkg::DATA_IN_W-1:0] new_value_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           hit_o,
  output logic [lfac_pkg::OUT_W-1:0]     found_value_o
);

  localparam int CMD_W = 2 + KEY_BITS + DATA_BITS;
  localparam int RES_W = $bits(lfac_pkg::result_t);

  logic                 fr_valid, fr_ready;
  lfac_pkg::cmd_kind_e  fr_kind;
  logic [KEY_BITS-1:0]  fr_key;
  logic [DATA_BITS-1:0] fr_value;

  logic                 cq_valid, cq_pop;
  logic [CMD_W-1:0]     cq_data;
  lfac_pkg::cmd_kind_e  be_kind;
  logic [KEY_BITS-1:0]  be_key;
  logic [DATA_BITS-1:0] be_value;

  logic                 be_res_valid, be_res_ready, rq_valid;
  lfac_pkg::result_t    be_res, rq_res;
  logic [RES_W-1:0]     rq_data;

  lfac_front #(
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .opcode_i     (opcode_i),
    .search_key_i (search_key_i),
    .new_value_i  (new_value_i),
    .cmd_valid_o  (fr_valid),
    .cmd_ready_i  (fr_ready),
    .cmd_kind_o   (fr_kind),
    .cmd_key_o    (fr_key),
    .cmd_value_o  (fr_value)
  );

  lfac_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  ({fr_kind, fr_key, fr_value}),
    .rd_valid_o (cq_valid),
    .rd_ready_i (cq_pop),
    .rd_data_o  (cq_data)
  );

  assign be_kind  = lfac_pkg::cmd_kind_e'(cq_data[CMD_W-1 -: 2]);
  assign be_key   = cq_data[DATA_BITS +: KEY_BITS];
  assign be_value = cq_data[DATA_BITS-1:0];

  lfac_back #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cq_valid),
    .cmd_pop_o   (cq_pop),
    .cmd_kind_i  (be_kind),
    .cmd_key_i   (be_key),
    .cmd_value_i (be_value),
    .res_valid_o (be_res_valid),
    .res_ready_i (be_res_ready),
    .res_o       (be_res)
  );

  lfac_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (be_res_valid),
    .wr_ready_o (be_res_ready),
    .wr_data_i  (be_res),
    .rd_valid_o (rq_valid),
    .rd_ready_i (pop),
    .rd_data_o  (rq_data)
  );

  assign rq_res        = lfac_pkg::result_t'(rq_data);
  assign empty         = !rq_valid;
  assign hit_o         = rq_res.hit;
  assign found_value_o = rq_res.found_value;

endmodule

// File: tb/sv/lru_cache_checker.sv
// Checker for the LRU cache: tracks the cache contents and compares every result beat.
`timescale 1ns / 1ps

module lru_cache_checker
  import lfac_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 full_i,
  input  logic [OPCODE_W-1:0]  opcode_i,
  input  logic [KEY_IN_W-1:0]  search_key_i,
  input  logic [DATA_IN_W-1:0] new_value_i,
  input  logic                 empty_i,
  input  logic                 pop_i,
  input  logic                 hit_i,
  input  logic [OUT_W-1:0]     found_value_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   hit_count_o
);

  localparam int RANK_W = $clog2(CAPACITY);

  logic [KEY_BITS-1:0]  tag_q  [CAPACITY];
  logic [DATA_BITS-1:0] word_q [CAPACITY];
  logic                 live_q [CAPACITY];
  logic [RANK_W-1:0]    age_q  [CAPACITY];
  result_t              pending_results [$];

  task automatic make_newest(input int slot);
    logic [RANK_W-1:0] old_age;
    old_age = age_q[slot];
    for (int i = 0; i < CAPACITY; i++) begin
      if (age_q[i] < old_age) begin
        age_q[i] = age_q[i] + 1'b1;
      end
    end
    age_q[slot] = '0;
  endtask

  task automatic apply_command(input logic [OPCODE_W-1:0] op,
                               input logic [KEY_IN_W-1:0] key,
                               input logic [DATA_IN_W-1:0] value,
                               output result_t res);
    int best;
    int best_age;
    int victim;
    res = '0;
    best = -1;
    best_age = CAPACITY;
    victim = 0;
    case (op)
      OP_LOOKUP: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (live_q[i] && tag_q[i] == key[KEY_BITS-1:0] && int'(age_q[i]) < best_age) begin
            best_age = age_q[i];
            best = i;
          end
        end
        if (best >= 0) begin
          res.hit = 1'b1;
          res.found_value = OUT_W'(word_q[best]);
          make_newest(best);
        end
      end
      OP_INSERT: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (int'(age_q[i]) == CAPACITY - 1) begin
            victim = i;
          end
        end
        tag_q[victim] = key[KEY_BITS-1:0];
        word_q[victim] = value[DATA_BITS-1:0];
        live_q[victim] = 1'b1;
        make_newest(victim);
      end
      OP_CLEAR: begin
        for (int i = 0; i < CAPACITY; i++) begin
          live_q[i] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) begin
        tag_q[i] = '0;
        word_q[i] = '0;
        live_q[i] = 1'b0;
        age_q[i] = RANK_W'(i);
      end
      pending_results.delete();
      pending_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        got.hit = hit_i;
        got.found_value = found_value_i;
        if (pending_results.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          $display("%0t: result beat with nothing expected: hit %b value %h",
                   $time, got.hit, got.found_value);
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit) begin
            fail_count_o = fail_count_o + 1;
            $display("%0t: hit mismatch: expected %b actual %b", $time, want.hit, got.hit);
          end
          if (got.found_value !== want.found_value) begin
            fail_count_o = fail_count_o + 1;
            $display("%0t: found_value mismatch: expected %h actual %h",
                     $time, want.found_value, got.found_value);
          end
          if (want.hit) begin
            hit_count_o = hit_count_o + 1;
          end
        end
      end
      if (push_i && !full_i) begin
        apply_command(opcode_i, search_key_i, new_value_i, want);
        pending_results.push_back(want);
      end
      pending_o = pending_results.size();
    end
  end

endmodule

// File: tb/sv/lru_fully_associative_cache_tb.sv
// Testbench top for the LRU cache: clock, reset, beat traffic and the verdict.
`timescale 1ns / 1ps

module lru_fully_associative_cache_tb;
  import lfac_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
  localparam int RANDOM_BEATS = 900;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int KEY_POOL     = 32;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [OPCODE_W-1:0]  opcode_i;
  logic [KEY_IN_W-1:0]  search_key_i;
  logic [DATA_IN_W-1:0] new_value_i;
  logic                 empty;
  logic                 pop;
  logic                 hit_o;
  logic [OUT_W-1:0]     found_value_o;

  int fail_count;
  int pending;
  int hit_count;
  int beats_sent;
  int lookups_sent;
  int inserts_sent;
  int clears_sent;
  int spares_sent;
  int cycle_count;
  bit quiet;
  bit hold_pop;
  logic [KEY_IN_W-1:0] key_pool [KEY_POOL];

  lru_fully_associative_cache u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .search_key_i (search_key_i),
    .new_value_i  (new_value_i),
    .empty        (empty),
    .pop          (pop),
    .hit_o        (hit_o),
    .found_value_o(found_value_o)
  );

  lru_cache_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .opcode_i     (opcode_i),
    .search_key_i (search_key_i),
    .new_value_i  (new_value_i),
    .empty_i      (empty),
    .pop_i        (pop),
    .hit_i        (hit_o),
    .found_value_i(found_value_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .hit_count_o  (hit_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Drain results, with random stalls and one long hold-off.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_pop || !rst_ni) begin
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 13) begin
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    hold_pop = 1'b0;
    wait (beats_sent >= 500);
    hold_pop = 1'b1;
    repeat (80) @(posedge clk_i);
    hold_pop = 1'b0;
  end

  task automatic send_beat(input logic [OPCODE_W-1:0] op,
                           input logic [KEY_IN_W-1:0] key,
                           input logic [DATA_IN_W-1:0] value);
    @(negedge clk_i);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    opcode_i <= op;
    search_key_i <= key;
    new_value_i <= value;
    do @(posedge clk_i); while (full);
    beats_sent++;
    case (op)
      OP_LOOKUP: lookups_sent++;
      OP_INSERT: inserts_sent++;
      OP_CLEAR:  clears_sent++;
      default:   spares_sent++;
    endcase
  endtask

  initial begin
    int pick;
    logic [KEY_IN_W-1:0] key;
    rst_ni = 1'b0;
    push = 1'b0;
    opcode_i = OP_LOOKUP;
    search_key_i = '0;
    new_value_i = '0;
    quiet = 1'b0;
    beats_sent = 0;
    lookups_sent = 0;
    inserts_sent = 0;
    clears_sent = 0;
    spares_sent = 0;
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i] = $urandom;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_beat(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(OP_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_beat(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_SPARE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(OP_LOOKUP, 32'h1234_5678, 32'h0000_0000);
    send_beat(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_beat(OP_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_beat(OP_LOOKUP, 32'hA5A5_A5A5, 32'h0000_0000);
    for (int i = 0; i < 8; i++) begin
      send_beat(OP_INSERT, 32'h8000_0000 | i, 32'hC000_0000 | i);
    end
    send_beat(OP_LOOKUP, 32'h8000_0003, 32'h0000_0000);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      quiet = (n >= 300 && n < 450);
      if (n == 700) begin
        @(negedge clk_i);
        push <= 1'b0;
        wait (pending == 0);
      end
      pick = $urandom_range(0, 99);
      key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      if (pick < 45) begin
        send_beat(OP_LOOKUP, key, $urandom);
      end else if (pick < 85) begin
        send_beat(OP_INSERT, key, $urandom);
      end else if (pick < 88) begin
        send_beat(OP_CLEAR, $urandom, $urandom);
      end else if (pick < 92) begin
        send_beat(OP_SPARE, key, $urandom);
      end else if (pick < 96) begin
        send_beat(OP_INSERT, $urandom, $urandom);
      end else begin
        send_beat(OP_LOOKUP, $urandom, $urandom);
      end
    end
    quiet = 1'b0;
    @(negedge clk_i);
    push <= 1'b0;

    wait (pending == 0);
    repeat (12) @(posedge clk_i);
    $display("Covered %0d beats: %0d lookups (%0d hits), %0d inserts, %0d clears, %0d unused.",
             beats_sent, lookups_sent, hit_count, inserts_sent, clears_sent, spares_sent);
    $display("Traffic included a long result hold-off, a full drain and duplicate keys.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
